@@ hdl/spm_pkg.sv @@
package spm_pkg;

  localparam int unsigned A_W    = 20;
  localparam int unsigned V_W    = 16;
  localparam int unsigned N_W    = 12;
  localparam int unsigned SP_W   = 20;
  localparam int unsigned LIM_W  = 16;
  localparam int unsigned NUM_W  = 57;
  localparam int unsigned DEN_W  = 38;
  localparam int unsigned CMP_W  = NUM_W + 1;
  localparam int unsigned DIV_STAGES = SP_W + 1;

  localparam logic [SP_W-1:0]  SPEEDUP_MAX = '1;
  localparam logic [LIM_W-1:0] CORES_MAX   = '1;
  localparam logic [SP_W-1:0]  ONE_Q8      = SP_W'(256);

  // Operands handed from the front end to the divider.
  typedef struct packed {
    logic              vld;
    logic              direct;
    logic [SP_W-1:0]   dval;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic [LIM_W-1:0]  lim;
  } spm_op_t;

endpackage

@@ hdl/spm_in_if.sv @@
interface spm_in_if;
  import spm_pkg::*;
  logic            valid;
  logic            ready;
  logic [A_W-1:0]  avg_parallelism;
  logic [V_W-1:0]  variance;
  logic [N_W-1:0]  core_count;
  modport source (output valid, avg_parallelism, variance, core_count, input ready);
  modport sink   (input valid, avg_parallelism, variance, core_count, output ready);
endinterface

@@ hdl/spm_out_if.sv @@
interface spm_out_if;
  import spm_pkg::*;
  logic              valid;
  logic              ready;
  logic [SP_W-1:0]   speedup;
  logic [LIM_W-1:0]  useful_cores_max;
  modport source (output valid, speedup, useful_cores_max, input ready);
  modport sink   (input valid, speedup, useful_cores_max, output ready);
endinterface

@@ hdl/spm_front.sv @@
module spm_front
  import spm_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_vld,
  input  logic [A_W-1:0]  a_in,
  input  logic [V_W-1:0]  v_in,
  input  logic [N_W-1:0]  n_in,
  output spm_op_t         op
);

  // Stage 1: products of the raw operands and the case compares.
  logic            vld1, small1, ca1, cb1;
  logic [A_W-1:0]  a1;
  logic [V_W-1:0]  v1;
  logic [N_W-1:0]  n1;
  logic [31:0]     an1;
  logic [27:0]     vnm1;
  logic [28:0]     vb1;
  logic [21:0]     nq1;
  logic [36:0]     pos1;
  logic [20:0]     s1;
  logic [LIM_W-1:0] lims1;

  logic [20:0] two_a;
  assign two_a = {a_in, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (adv) begin
      vld1 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1     <= a_in;
      v1     <= v_in;
      n1     <= n_in;
      small1 <= (v_in < V_W'(256));
      an1    <= 32'(a_in) * 32'(n_in);
      vnm1   <= 28'(v_in) * 28'(n_in - N_W'(1));
      vb1    <= 29'(v_in[7:0]) * 29'(two_a - 21'd256);
      nq1    <= 22'(n_in) * (22'd512 - 22'(v_in[7:0]));
      pos1   <= 37'(a_in) * (37'(v_in) + 37'd256);
      s1     <= 21'({n_in, 8'b0}) + 21'(a_in) - 21'd256;
      ca1    <= (21'({n_in, 8'b0}) <= 21'(a_in));
      cb1    <= (22'({n_in, 8'b0}) + 22'd256 <= 22'(two_a));
      lims1  <= (two_a > 21'd256) ? LIM_W'((two_a - 21'd1) >> 8) : '0;
    end
  end

  // Stage 2: second-level products and the large-variance limit.
  logic            vld2, small2, ca2, cb2, cc2;
  logic [A_W-1:0]  a2;
  logic [N_W-1:0]  n2;
  logic [48:0]     anv2;
  logic [36:0]     vs2;
  logic [21:0]     dena2;
  logic [30:0]     denb2;
  logic [48:0]     numb2;
  logic [LIM_W-1:0] lim2;
  logic [37:0]     lim_raw;
  logic [36:0]     diff1;

  always_comb begin
    diff1   = pos1 - 37'({v1, 8'b0});
    lim_raw = (38'(diff1) + 38'd65535) >> 16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (adv) begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2     <= a1;
      n2     <= n1;
      small2 <= small1;
      ca2    <= ca1;
      cb2    <= cb1;
      cc2    <= (38'({n1, 16'b0}) + 38'({v1, 8'b0}) <= 38'(pos1));
      anv2   <= 49'(an1) * (49'(v1) + 49'd256);
      vs2    <= 37'(v1) * 37'(s1);
      dena2  <= 22'({a1, 1'b0}) + 22'(vnm1);
      denb2  <= 31'(vb1) + 31'({nq1, 8'b0});
      numb2  <= {an1, 17'b0};
      if (small1) begin
        lim2 <= lims1;
      end else if (pos1 > 37'({v1, 8'b0})) begin
        lim2 <= (lim_raw > 38'(CORES_MAX)) ? CORES_MAX : LIM_W'(lim_raw);
      end else begin
        lim2 <= '0;
      end
    end
  end

  // Stage 3: choose the case and form numerator and denominator.
  spm_op_t op_next;

  always_comb begin
    op_next        = '0;
    op_next.vld    = vld2;
    op_next.lim    = lim2;
    op_next.direct = 1'b1;
    op_next.dval   = a2;
    op_next.num    = NUM_W'({anv2, 8'b0});
    op_next.den    = DEN_W'(vs2) + DEN_W'({a2, 8'b0});
    if (n2 == '0) begin
      op_next.dval = '0;
    end else if (small2) begin
      if (n2 == N_W'(1)) begin
        op_next.dval = ONE_Q8;
      end else if (ca2) begin
        op_next.direct = 1'b0;
        op_next.num    = NUM_W'({numb2[48:17], 9'b0});
        op_next.den    = DEN_W'(dena2);
      end else if (cb2) begin
        op_next.direct = 1'b0;
        op_next.num    = NUM_W'(numb2);
        op_next.den    = DEN_W'(denb2);
      end
    end else if (cc2) begin
      op_next.direct = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op.vld <= 1'b0;
    end else if (adv) begin
      op.vld <= op_next.vld;
    end
    if (adv) begin
      op.lim    <= op_next.lim;
      op.direct <= op_next.direct;
      op.dval   <= op_next.dval;
      op.num    <= op_next.num;
      op.den    <= op_next.den;
    end
  end

endmodule

@@ hdl/spm_div.sv @@
module spm_div
  import spm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  spm_op_t           op,
  output logic              out_vld,
  output logic [SP_W-1:0]   speedup,
  output logic [LIM_W-1:0]  lim
);

  logic             vld_r  [DIV_STAGES];
  logic             dir_r  [DIV_STAGES];
  logic             sat_r  [DIV_STAGES];
  logic [SP_W-1:0]  q_r    [DIV_STAGES];
  logic [NUM_W-1:0] rem_r  [DIV_STAGES];
  logic [DEN_W-1:0] den_r  [DIV_STAGES];
  logic [LIM_W-1:0] lim_r  [DIV_STAGES];

  // Stage 0 flags a quotient that does not fit the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= op.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dir_r[0] <= op.direct;
      sat_r[0] <= (CMP_W'(op.num) >= (CMP_W'(op.den) << SP_W));
      q_r[0]   <= op.dval;
      rem_r[0] <= op.num;
      den_r[0] <= op.den;
      lim_r[0] <= op.lim;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
    localparam int unsigned B = SP_W - k;
    logic [CMP_W-1:0] dsh;
    logic             take;
    logic [SP_W-1:0]  q_next;

    always_comb begin
      dsh    = CMP_W'(den_r[k-1]) << B;
      take   = !dir_r[k-1] && !sat_r[k-1] && (CMP_W'(rem_r[k-1]) >= dsh);
      q_next = q_r[k-1];
      if (!dir_r[k-1]) begin
        q_next[B] = take;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dir_r[k] <= dir_r[k-1];
        sat_r[k] <= sat_r[k-1];
        den_r[k] <= den_r[k-1];
        lim_r[k] <= lim_r[k-1];
        rem_r[k] <= take ? NUM_W'(CMP_W'(rem_r[k-1]) - dsh) : rem_r[k-1];
        q_r[k]   <= q_next;
      end
    end
  end

  assign out_vld = vld_r[DIV_STAGES-1];
  assign lim     = lim_r[DIV_STAGES-1];
  assign speedup = (!dir_r[DIV_STAGES-1] && sat_r[DIV_STAGES-1]) ? SPEEDUP_MAX
                                                                  : q_r[DIV_STAGES-1];

endmodule

@@ hdl/parallel_speedup_model_core.sv @@
// Channel  Direction  Payload
// in_ch    sink       avg_parallelism (Q12.8), variance (Q8.8), core_count
// out_ch   source     speedup (Q12.8), useful_cores_max
//
// One transaction per cycle is accepted unless stalled; results pass three
// operand stages and a 21-stage restoring divider (a saturation check, then
// one quotient bit per stage). Reset clears only the valid bits of the
// pipeline. When the output result is not taken, the whole pipeline holds
// and in_ch.ready drops; a cycle with an empty output stage always advances.
module parallel_speedup_model_core
  import spm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  spm_in_if.sink        in_ch,
  spm_out_if.source     out_ch
);

  logic    adv;
  logic    out_vld;
  spm_op_t op;

  // The pipeline advances whenever the output stage is empty or drained.
  assign adv         = !out_vld || out_ch.ready;
  assign in_ch.ready = adv;

  // Operand preparation: case selection, products, numerator and divisor.
  spm_front u_front (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .in_vld (in_ch.valid),
    .a_in   (in_ch.avg_parallelism),
    .v_in   (in_ch.variance),
    .n_in   (in_ch.core_count),
    .op     (op)
  );

  // Pipelined division with saturation of oversized quotients.
  spm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .op      (op),
    .out_vld (out_vld),
    .speedup (out_ch.speedup),
    .lim     (out_ch.useful_cores_max)
  );

  assign out_ch.valid = out_vld;

  // A quotient is only ever requested with a nonzero divisor.
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (op.vld && !op.direct) |-> (op.den != '0))
    else $error("divider fed a zero divisor");

  // A held result blocks new input.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted during output stall");

  // A held result is still there in the next cycle.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !out_ch.ready) |=> (out_vld && $stable(out_ch.speedup)))
    else $error("stalled result lost");

endmodule
